// ===== sv/bfm_pkg.sv =====
// ----------------------------------------------------------------------------
// bfm_pkg
// Shared widths, register indexes, reset values and item records for the
// 3x3 box mean filter.
// ----------------------------------------------------------------------------
package bfm_pkg;

   // Default sizes handed to the top level parameters
   localparam int MAX_WIDTH_DEF    = 1024;
   localparam int MAX_HEIGHT_DEF   = 4096;
   localparam int NUM_CHANNELS_DEF = 3;

   // Field widths
   localparam int CH_W   = 8;
   localparam int OUT_CH = 3;
   localparam int PIX_W  = CH_W * OUT_CH;
   localparam int ROW_W  = 12;
   localparam int COL_W  = 10;
   localparam int SUM_W  = 12;   // nine samples of 255 stay below 4096

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int WIDTH_W    = 11;
   localparam int HEIGHT_W   = 13;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_COLOR_MODE   = 2'd2
   } csr_index_type;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
   localparam logic                COLOR_RESET  = 1'b1;

   // floor(s / 9) = (s * 7282) >> 16, exact for s below 4096
   localparam int               DIV9_RECIP_W = 13;
   localparam logic [12:0]      DIV9_RECIP   = 13'd7282;
   localparam int               DIV9_SHIFT   = 16;
   localparam int               PROD_W       = SUM_W + DIV9_RECIP_W;

   // Result queue
   localparam int QUEUE_DEPTH = 8;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Everything one input item produces: an interior and/or a border result
   typedef struct packed {
      logic             has_int;
      logic             has_bdr;
      logic [ROW_W-1:0] int_row;
      logic [COL_W-1:0] int_col;
      logic [ROW_W-1:0] bdr_row;
      logic [COL_W-1:0] bdr_col;
      logic [PIX_W-1:0] mean;
      logic [PIX_W-1:0] pix;
   } step_type;

   // One result item as it leaves the block
   typedef struct packed {
      logic [ROW_W-1:0] out_row;
      logic [COL_W-1:0] out_col;
      logic             is_border;
      logic [CH_W-1:0]  result_ch0;
      logic [CH_W-1:0]  result_ch1;
      logic [CH_W-1:0]  result_ch2;
      logic             last_of_step;
   } result_type;

endpackage

// ===== sv/bfm_line_store.sv =====
// ----------------------------------------------------------------------------
// bfm_line_store
// Line memory holding the two previous rows per column, one entry per
// column: {older row, newer row}. One write port, one registered read port.
// ----------------------------------------------------------------------------
module bfm_line_store
   import bfm_pkg::*;
#(
   parameter int DEPTH = MAX_WIDTH_DEF,
   parameter int AW    = $clog2(MAX_WIDTH_DEF),
   parameter int DW    = 2 * CH_W * NUM_CHANNELS_DEF
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // Write the updated column pair
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read; same-address reads return old data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/bfm_window_sum.sv =====
// ----------------------------------------------------------------------------
// bfm_window_sum
// Two previous columns of the 3-row window and the per-channel sum of the
// full 3x3 neighborhood, registered.
// ----------------------------------------------------------------------------
module bfm_window_sum
   import bfm_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
   input  logic                                    clock,
   input  logic                                    shift,
   input  logic [CH_W*NUM_CHANNELS-1:0]            top,
   input  logic [CH_W*NUM_CHANNELS-1:0]            mid,
   input  logic [CH_W*NUM_CHANNELS-1:0]            cur,
   output logic [NUM_CHANNELS-1:0][SUM_W-1:0]      sum
);

   localparam int DW = CH_W * NUM_CHANNELS;

   // Entries 0..2: column c-2 (top, mid, cur); entries 3..5: column c-1
   logic [DW-1:0]                    win_ff [6];
   logic [NUM_CHANNELS-1:0][SUM_W-1:0] sum_in;
   logic [NUM_CHANNELS-1:0][SUM_W-1:0] sum_ff;

   // Add the nine samples of each channel
   for (genvar k = 0; k < NUM_CHANNELS; k++) begin : g_ch
      assign sum_in[k] = SUM_W'(win_ff[0][CH_W*k +: CH_W]) + SUM_W'(win_ff[1][CH_W*k +: CH_W])
                       + SUM_W'(win_ff[2][CH_W*k +: CH_W]) + SUM_W'(win_ff[3][CH_W*k +: CH_W])
                       + SUM_W'(win_ff[4][CH_W*k +: CH_W]) + SUM_W'(win_ff[5][CH_W*k +: CH_W])
                       + SUM_W'(top[CH_W*k +: CH_W]) + SUM_W'(mid[CH_W*k +: CH_W])
                       + SUM_W'(cur[CH_W*k +: CH_W]);
   end

   // Advance the window by one column per item
   always_ff @(posedge clock) begin
      if (shift) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top;
         win_ff[4] <= mid;
         win_ff[5] <= cur;
      end
      sum_ff <= sum_in;
   end

   assign sum = sum_ff;

endmodule

// ===== sv/bfm_out_queue.sv =====
// ----------------------------------------------------------------------------
// bfm_out_queue
// Queue of per-item records. Emits the interior result of a record first,
// then its border result, one result item per handshake.
// ----------------------------------------------------------------------------
module bfm_out_queue
   import bfm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  step_type         push_step,
   output logic [CNT_W-1:0] count,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output result_type       rsp_item
);

   step_type         q_mem [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             second_ff;   // interior part of the head already sent
   step_type         head;
   logic             emit_int;
   logic             take;
   logic             pop;

   assign head      = q_mem[rd_ptr_ff];
   assign rsp_valid = (count_ff != '0);
   assign emit_int  = head.has_int && !second_ff;
   assign take      = rsp_valid && !rsp_stall;
   assign pop       = take && !(emit_int && head.has_bdr);
   assign count     = count_ff;

   // Select the interior or the border part of the head record
   always_comb begin
      rsp_item.out_row      = emit_int ? head.int_row : head.bdr_row;
      rsp_item.out_col      = emit_int ? head.int_col : head.bdr_col;
      rsp_item.is_border    = !emit_int;
      rsp_item.result_ch0   = emit_int ? head.mean[0 +: CH_W]      : head.pix[0 +: CH_W];
      rsp_item.result_ch1   = emit_int ? head.mean[CH_W +: CH_W]   : head.pix[CH_W +: CH_W];
      rsp_item.result_ch2   = emit_int ? head.mean[2*CH_W +: CH_W] : head.pix[2*CH_W +: CH_W];
      rsp_item.last_of_step = emit_int ? !head.has_bdr : 1'b1;
   end

   // Store records
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= push_step;
      end
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         second_ff <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (take) begin
            second_ff <= !pop;
         end
         count_ff <= count_ff + CNT_W'(push) - CNT_W'(pop);
      end
   end

endmodule

// ===== sv/box_filter_3x3_mean.sv =====
// ----------------------------------------------------------------------------
// box_filter_3x3_mean
// 3x3 box mean filter over a raster pixel stream, gray or three channels.
// Pipeline: an accepted item passes the line memory read, the window sum and
//   the divide by nine before its result items wait in the result queue.
// Throughput: one item per cycle while req_stall is low; an item with two
//   results takes two output handshakes and the result queue absorbs that.
// Reset: synchronous; clears counters, pipeline and queue, and loads the
//   size and mode registers. The line memory is not cleared.
// ----------------------------------------------------------------------------
module box_filter_3x3_mean
   import bfm_pkg::*;
#(
   parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT   = MAX_HEIGHT_DEF,
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_start_of_frame,
   input  logic [CH_W-1:0]       req_pixel_ch0,
   input  logic [CH_W-1:0]       req_pixel_ch1,
   input  logic [CH_W-1:0]       req_pixel_ch2,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [ROW_W-1:0]      rsp_out_row,
   output logic [COL_W-1:0]      rsp_out_col,
   output logic                  rsp_is_border,
   output logic [CH_W-1:0]       rsp_result_ch0,
   output logic [CH_W-1:0]       rsp_result_ch1,
   output logic [CH_W-1:0]       rsp_result_ch2,
   output logic                  rsp_last_of_step,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int DW = CH_W * NUM_CHANNELS;

   // Configuration
   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic                color_ff;
   logic [CW:0]         w_eff;
   logic [RW:0]         h_eff;

   // Stage A: accept, position, line memory read
   logic          accept;
   logic [RW-1:0] row_ff, r_a;
   logic [CW-1:0] col_ff, c_a;
   logic [RW:0]   r_ext, r_inc;
   logic [CW:0]   c_ext, c_inc;
   logic          interior_a, border_a, col_wrap, row_wrap;
   logic [PIX_W-1:0] pix3;
   logic [DW-1:0] cur_a;
   logic          fwd_in;

   // Stage B: line data, write back, window
   logic            vb_ff;
   logic [RW-1:0]   rb_ff;
   logic [CW-1:0]   cb_ff;
   logic [DW-1:0]   curb_ff;
   logic            intb_ff, bdrb_ff;
   logic            fwdb_ff;
   logic [2*DW-1:0] fwdb_data_ff;
   logic [2*DW-1:0] line_rd, line_b, wr_line;
   logic [DW-1:0]   top_b, mid_b;

   // Stage C: divide, build record
   logic                              vc_ff;
   logic [RW-1:0]                     rc_ff;
   logic [CW-1:0]                     cc_ff;
   logic [DW-1:0]                     curc_ff;
   logic                              intc_ff, bdrc_ff;
   logic [NUM_CHANNELS-1:0][SUM_W-1:0] sum_c;
   logic [PIX_W-1:0]                  mean24;
   logic [31:0]                       row_x, row_m1, col_x, col_m1;
   step_type                          step_in;
   logic                              push;

   // Output queue
   logic [CNT_W-1:0] q_count;
   logic [CNT_W:0]   used;
   result_type       rsp_item;

   // Hold the size and mode registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         color_ff  <= COLOR_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wr_data[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wr_data[HEIGHT_W-1:0];
            CSR_COLOR_MODE:   color_ff  <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   // Clamp the frame size to 1..MAX
   always_comb begin
      if (width_ff == '0) begin
         w_eff = (CW+1)'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = (CW+1)'(MAX_WIDTH);
      end else begin
         w_eff = (CW+1)'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = (RW+1)'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = (RW+1)'(MAX_HEIGHT);
      end else begin
         h_eff = (RW+1)'(height_ff);
      end
   end

   // Hold off new items unless the queue has room for every item in flight
   assign used      = {1'b0, q_count} + (CNT_W+1)'(vb_ff) + (CNT_W+1)'(vc_ff);
   assign req_stall = (used >= (CNT_W+1)'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   // Position of the incoming pixel and its classification
   assign r_a        = req_start_of_frame ? '0 : row_ff;
   assign c_a        = req_start_of_frame ? '0 : col_ff;
   assign r_ext      = {1'b0, r_a};
   assign c_ext      = {1'b0, c_a};
   assign r_inc      = r_ext + (RW+1)'(1);
   assign c_inc      = c_ext + (CW+1)'(1);
   assign row_wrap   = (r_inc >= h_eff);
   assign col_wrap   = (c_inc >= w_eff);
   assign interior_a = (r_ext >= (RW+1)'(2)) && (c_ext >= (CW+1)'(2))
                    && (r_ext < h_eff) && (c_ext < w_eff);
   assign border_a   = (r_a == '0) || (c_a == '0) || row_wrap || col_wrap;

   // Drop unused channels in gray mode
   assign pix3  = {color_ff ? req_pixel_ch2 : '0, color_ff ? req_pixel_ch1 : '0, req_pixel_ch0};
   assign cur_a = pix3[DW-1:0];

   // Forward the entry being written when the next item reads the same column
   assign fwd_in = vb_ff && (cb_ff == c_a);

   // Advance position counters and pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         vb_ff  <= 1'b0;
         vc_ff  <= 1'b0;
      end else begin
         vb_ff <= accept;
         vc_ff <= vb_ff;
         if (accept) begin
            if (col_wrap) begin
               col_ff <= '0;
               row_ff <= row_wrap ? '0 : r_inc[RW-1:0];
            end else begin
               col_ff <= c_inc[CW-1:0];
               row_ff <= r_a;
            end
         end
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      rb_ff        <= r_a;
      cb_ff        <= c_a;
      curb_ff      <= cur_a;
      intb_ff      <= interior_a;
      bdrb_ff      <= border_a;
      fwdb_ff      <= fwd_in;
      fwdb_data_ff <= wr_line;
      rc_ff        <= rb_ff;
      cc_ff        <= cb_ff;
      curc_ff      <= curb_ff;
      intc_ff      <= intb_ff;
      bdrc_ff      <= bdrb_ff;
   end

   bfm_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW),
      .DW    (2*DW)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (c_a),
      .rd_data (line_rd),
      .wr_en   (vb_ff),
      .wr_addr (cb_ff),
      .wr_data (wr_line)
   );

   // Shift the column pair down one row and write back
   assign line_b  = fwdb_ff ? fwdb_data_ff : line_rd;
   assign top_b   = line_b[2*DW-1:DW];
   assign mid_b   = line_b[DW-1:0];
   assign wr_line = {mid_b, curb_ff};

   bfm_window_sum #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_window_sum (
      .clock (clock),
      .shift (vb_ff),
      .top   (top_b),
      .mid   (mid_b),
      .cur   (curb_ff),
      .sum   (sum_c)
   );

   // Divide each channel sum by nine
   always_comb begin
      logic [PROD_W-1:0] prod;
      mean24 = '0;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         prod = PROD_W'(sum_c[k]) * PROD_W'(DIV9_RECIP);
         mean24[CH_W*k +: CH_W] = prod[DIV9_SHIFT +: CH_W];
      end
   end

   // Build the record for the queue
   assign row_x  = 32'(rc_ff);
   assign col_x  = 32'(cc_ff);
   assign row_m1 = row_x - 32'd1;
   assign col_m1 = col_x - 32'd1;

   always_comb begin
      step_in.has_int = intc_ff;
      step_in.has_bdr = bdrc_ff;
      step_in.int_row = row_m1[ROW_W-1:0];
      step_in.int_col = col_m1[COL_W-1:0];
      step_in.bdr_row = row_x[ROW_W-1:0];
      step_in.bdr_col = col_x[COL_W-1:0];
      step_in.mean    = mean24 & {{(2*CH_W){color_ff}}, {CH_W{1'b1}}};
      step_in.pix     = PIX_W'(curc_ff);
   end

   assign push = vc_ff && (intc_ff || bdrc_ff);

   bfm_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_step (step_in),
      .count     (q_count),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   assign rsp_out_row      = rsp_item.out_row;
   assign rsp_out_col      = rsp_item.out_col;
   assign rsp_is_border    = rsp_item.is_border;
   assign rsp_result_ch0   = rsp_item.result_ch0;
   assign rsp_result_ch1   = rsp_item.result_ch1;
   assign rsp_result_ch2   = rsp_item.result_ch2;
   assign rsp_last_of_step = rsp_item.last_of_step;

endmodule

// ===== sv/bfm_checker.sv =====
// ----------------------------------------------------------------------------
// bfm_checker
// Port-level checks on the result channel of the box mean filter.
// ----------------------------------------------------------------------------
module bfm_checker
   import bfm_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [ROW_W-1:0] rsp_out_row,
   input logic [COL_W-1:0] rsp_out_col,
   input logic             rsp_is_border,
   input logic [CH_W-1:0]  rsp_result_ch0,
   input logic [CH_W-1:0]  rsp_result_ch1,
   input logic [CH_W-1:0]  rsp_result_ch2,
   input logic             rsp_last_of_step
);

   // Hold a stalled result item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_row) && $stable(rsp_out_col)
         && $stable(rsp_is_border) && $stable(rsp_result_ch0) && $stable(rsp_result_ch1)
         && $stable(rsp_result_ch2) && $stable(rsp_last_of_step))
      else $error("result item changed while stalled");

   // Nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // Only an interior result can be followed by a second result of the same item
   a_pair_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_step |-> !rsp_is_border)
      else $error("border result not last of its item");

   // The border result follows at once, one row and one column further on
   a_pair_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_step |=> rsp_valid && rsp_is_border
         && rsp_last_of_step && rsp_out_row == $past(rsp_out_row) + ROW_W'(1)
         && rsp_out_col == $past(rsp_out_col) + COL_W'(1))
      else $error("second result of an item missing or misplaced");

endmodule

bind box_filter_3x3_mean bfm_checker u_bfm_checker (.*);

// ===== tb/tb_box_filter_3x3_mean.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_box_filter_3x3_mean
// Self-checking bench for the 3x3 box mean filter. A behavioral copy of the
// filter predicts every result item from each accepted pixel, and a monitor
// compares the result stream against it in order. Directed cases cover pixel
// extremes, the smallest full frame, zero and oversized formats, and formats
// shrunk under a running frame. A back-pressure case holds the output off
// long enough that the input stalls. Random frames of varied size, mode and
// content follow, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_box_filter_3x3_mean;
   import bfm_pkg::*;

   localparam int RANDOM_PIXELS = 976;
   localparam int DRAIN_CYCLES  = 12;
   localparam int NEIGHBORS     = 9;
   localparam int WINDOW_COLS   = 6;
   localparam int MAX_REPORTS   = 10;
   localparam int LINE_AW       = $clog2(MAX_WIDTH_DEF);

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_start_of_frame;
   logic [CH_W-1:0]       req_pixel_ch0;
   logic [CH_W-1:0]       req_pixel_ch1;
   logic [CH_W-1:0]       req_pixel_ch2;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [ROW_W-1:0]      rsp_out_row;
   logic [COL_W-1:0]      rsp_out_col;
   logic                  rsp_is_border;
   logic [CH_W-1:0]       rsp_result_ch0;
   logic [CH_W-1:0]       rsp_result_ch1;
   logic [CH_W-1:0]       rsp_result_ch2;
   logic                  rsp_last_of_step;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   box_filter_3x3_mean uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_start_of_frame (req_start_of_frame),
      .req_pixel_ch0      (req_pixel_ch0),
      .req_pixel_ch1      (req_pixel_ch1),
      .req_pixel_ch2      (req_pixel_ch2),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_row        (rsp_out_row),
      .rsp_out_col        (rsp_out_col),
      .rsp_is_border      (rsp_is_border),
      .rsp_result_ch0     (rsp_result_ch0),
      .rsp_result_ch1     (rsp_result_ch1),
      .rsp_result_ch2     (rsp_result_ch2),
      .rsp_last_of_step   (rsp_last_of_step),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data)
   );

   // Filter state as the bench sees it
   logic [WIDTH_W-1:0]  cfg_width;
   logic [HEIGHT_W-1:0] cfg_height;
   logic                cfg_color;
   logic [PIX_W-1:0]    older_line [MAX_WIDTH_DEF];
   logic [PIX_W-1:0]    newer_line [MAX_WIDTH_DEF];
   logic [PIX_W-1:0]    window_px  [WINDOW_COLS];
   int unsigned         row_pos;
   int unsigned         col_pos;

   result_type expected_pixels[$];

   // Idling controls and run statistics
   int unsigned req_gap_max   = 0;
   int unsigned rsp_gap_max   = 0;
   int unsigned rsp_wait_left = 0;
   int unsigned hold_off_left = 0;
   int unsigned pixels_sent     = 0;
   int unsigned results_checked = 0;
   int unsigned frame_starts    = 0;
   int unsigned formats_used    = 0;
   int unsigned error_count     = 0;

   // Clock, 10 ns period
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Build one result item, masking the upper channels in gray mode
   function automatic result_type make_result(input int unsigned r, input int unsigned c,
                                              input logic border, input logic [PIX_W-1:0] px,
                                              input logic last);
      result_type res;
      res.out_row      = r[ROW_W-1:0];
      res.out_col      = c[COL_W-1:0];
      res.is_border    = border;
      res.result_ch0   = px[CH_W-1:0];
      res.result_ch1   = cfg_color ? px[2*CH_W-1:CH_W] : '0;
      res.result_ch2   = cfg_color ? px[3*CH_W-1:2*CH_W] : '0;
      res.last_of_step = last;
      return res;
   endfunction

   // Advance the filter by one pixel and queue the results it causes
   task automatic predict_box_mean(input logic sof, input logic [CH_W-1:0] p0,
                                   input logic [CH_W-1:0] p1, input logic [CH_W-1:0] p2);
      int unsigned        w, h, r, c, acc, k, j;
      logic [LINE_AW-1:0] ci;
      logic [PIX_W-1:0]   cur, top, mid, mean;
      logic               interior, border;
      w = (cfg_width == 0) ? 1 : cfg_width;
      if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
      h = (cfg_height == 0) ? 1 : cfg_height;
      if (h > MAX_HEIGHT_DEF) h = MAX_HEIGHT_DEF;
      if (sof) begin
         row_pos = 0;
         col_pos = 0;
      end
      r = row_pos;
      c = col_pos;
      ci = c[LINE_AW-1:0];
      cur = cfg_color ? {p2, p1, p0} : {{(2*CH_W){1'b0}}, p0};
      top = (c < MAX_WIDTH_DEF) ? older_line[ci] : '0;
      mid = (c < MAX_WIDTH_DEF) ? newer_line[ci] : '0;

      // Sum the 3x3 neighborhood per channel
      interior = (r >= 2) && (c >= 2) && (r < h) && (c < w);
      mean = '0;
      if (interior) begin
         for (k = 0; k < OUT_CH; k++) begin
            acc = top[CH_W*k +: CH_W] + mid[CH_W*k +: CH_W] + cur[CH_W*k +: CH_W];
            for (j = 0; j < WINDOW_COLS; j++) acc += window_px[j][CH_W*k +: CH_W];
            mean[CH_W*k +: CH_W] = CH_W'(acc / NEIGHBORS);
         end
      end

      // Shift line stores and window
      if (c < MAX_WIDTH_DEF) begin
         older_line[ci] = mid;
         newer_line[ci] = cur;
      end
      window_px[0] = window_px[3];
      window_px[1] = window_px[4];
      window_px[2] = window_px[5];
      window_px[3] = top;
      window_px[4] = mid;
      window_px[5] = cur;

      // Interior result first, then the border pass-through
      border = (r == 0) || (c == 0) || (r + 1 >= h) || (c + 1 >= w);
      if (interior) expected_pixels.push_back(make_result(r - 1, c - 1, 1'b0, mean, !border));
      if (border) expected_pixels.push_back(make_result(r, c, 1'b1, cur, 1'b1));

      // Advance the raster position
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endtask

   // Offer one pixel after a random gap and hold it until accepted
   task automatic send_pixel(input logic sof, input logic [CH_W-1:0] p0,
                             input logic [CH_W-1:0] p1, input logic [CH_W-1:0] p2);
      int unsigned gap;
      gap = $urandom_range(0, req_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_start_of_frame <= sof;
      req_pixel_ch0      <= p0;
      req_pixel_ch1      <= p1;
      req_pixel_ch2      <= p2;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_box_mean(sof, p0, p1, p2);
      pixels_sent++;
      if (sof) frame_starts++;
   endtask

   // Drop valid, drain all expected results, then let the pipeline settle
   task automatic wait_until_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write one register; the bench copy follows at once since the block is idle
   task automatic write_register(input csr_index_type idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH:  cfg_width  = value[WIDTH_W-1:0];
         CSR_IMAGE_HEIGHT: cfg_height = value[HEIGHT_W-1:0];
         CSR_COLOR_MODE:   cfg_color  = value[0];
         default: ;
      endcase
   endtask

   task automatic configure_frame(input int unsigned w, input int unsigned h,
                                  input logic color);
      wait_until_idle();
      write_register(CSR_IMAGE_WIDTH, CSR_DATA_W'(w));
      write_register(CSR_IMAGE_HEIGHT, CSR_DATA_W'(h));
      write_register(CSR_COLOR_MODE, CSR_DATA_W'(color));
      formats_used++;
   endtask

   // Pick a channel level in the given style
   function automatic logic [CH_W-1:0] draw_level(input int unsigned style);
      case (style)
         1:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         2:       return CH_W'($urandom_range(240, 255));
         3:       return CH_W'($urandom_range(0, 15));
         default: return CH_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Defaults after reset: first row of a 640x480 colour frame
   task automatic test_reset_defaults();
      req_gap_max = 2;
      rsp_gap_max = 2;
      send_pixel(1'b0, 8'h00, 8'hFF, 8'h00);
      send_pixel(1'b0, 8'hFF, 8'h00, 8'hFF);
   endtask

   // Smallest frame with an interior pixel; its last pixel yields two results
   task automatic test_smallest_frame();
      int unsigned i;
      configure_frame(3, 3, 1'b1);
      for (i = 0; i < 9; i++) send_pixel(i == 0, 8'hFF, 8'h00, 8'(i * 31));
   endtask

   // Zero sizes act as one; oversized sizes saturate
   task automatic test_size_limits();
      configure_frame(0, 0, 1'b1);
      send_pixel(1'b1, 8'h5A, 8'hA5, 8'hFF);
      send_pixel(1'b0, 8'hA5, 8'h5A, 8'h00);
      configure_frame((1 << WIDTH_W) - 1, (1 << HEIGHT_W) - 1, 1'b0);
      send_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(1'b0, 8'h00, 8'hFF, 8'hFF);
      send_pixel(1'b0, 8'h80, 8'hFF, 8'hFF);
   endtask

   // Shrink width, then height, under a running frame
   task automatic test_shrunken_format();
      int unsigned i;
      configure_frame(4, 4, 1'b1);
      for (i = 0; i < 6; i++) send_pixel(i == 0, draw_level(0), draw_level(0), draw_level(0));
      wait_until_idle();
      write_register(CSR_IMAGE_WIDTH, CSR_DATA_W'(2));
      send_pixel(1'b0, draw_level(0), draw_level(0), draw_level(0));
      wait_until_idle();
      write_register(CSR_IMAGE_HEIGHT, CSR_DATA_W'(2));
      for (i = 0; i < 3; i++) send_pixel(1'b0, draw_level(0), draw_level(0), draw_level(0));
   endtask

   // Hold the output off long enough that the block stalls its input
   task automatic test_backpressure();
      int unsigned i;
      configure_frame(8, 6, 1'b1);
      req_gap_max = 0;
      rsp_gap_max = 0;
      for (i = 0; i < 48; i++) begin
         send_pixel(i == 0, draw_level(0), draw_level(0), draw_level(0));
         if (i == 0) hold_off_left = 80;
      end
   endtask

   // Random formats, mostly whole frames, with restarts and cut frames mixed in
   task automatic test_random_frames();
      int unsigned random_pixels, w, h, frames, f, i, n, cut_at, style;
      logic        color, sof, need_sof;
      random_pixels = 0;
      while (random_pixels < RANDOM_PIXELS) begin
         case ($urandom_range(0, 7))
            0:       w = $urandom_range(1, 2);
            1:       w = $urandom_range(13, 40);
            default: w = $urandom_range(3, 12);
         endcase
         case ($urandom_range(0, 7))
            0:       h = $urandom_range(1, 2);
            1:       h = $urandom_range(11, 30);
            default: h = $urandom_range(3, 10);
         endcase
         if (w * h > 240) h = 240 / w;
         color = 1'($urandom_range(0, 1));
         style = $urandom_range(0, 5);
         configure_frame(w, h, color);
         req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
         rsp_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
         frames = $urandom_range(1, 3);
         need_sof = 1'b1;
         for (f = 0; f < frames; f++) begin
            n = w * h;
            cut_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, n) : n;
            for (i = 0; i < cut_at && random_pixels < RANDOM_PIXELS; i++) begin
               sof = (i == 0) && (need_sof || $urandom_range(0, 1));
               if ($urandom_range(0, 99) == 0) sof = 1'b1;
               send_pixel(sof, draw_level(style), draw_level(style), draw_level(style));
               random_pixels++;
               need_sof = 1'b0;
            end
            if (cut_at < n) need_sof = 1'b1;
         end
      end
   endtask

   // Stall the result side: long hold-off first, then the per-item wait
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_stall <= 1'b1;
         hold_off_left--;
      end else if (rsp_wait_left > 0) begin
         rsp_stall <= 1'b1;
         rsp_wait_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Check each accepted result against the oldest expectation
   always @(posedge clock) begin
      result_type seen, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.out_row      = rsp_out_row;
         seen.out_col      = rsp_out_col;
         seen.is_border    = rsp_is_border;
         seen.result_ch0   = rsp_result_ch0;
         seen.result_ch1   = rsp_result_ch1;
         seen.result_ch2   = rsp_result_ch2;
         seen.last_of_step = rsp_last_of_step;
         rsp_wait_left = $urandom_range(0, rsp_gap_max);
         results_checked++;
         if (expected_pixels.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: unexpected result row %0d col %0d", $realtime,
                        seen.out_row, seen.out_col);
         end else begin
            want = expected_pixels.pop_front();
            if (seen.out_row !== want.out_row || seen.out_col !== want.out_col ||
                seen.is_border !== want.is_border ||
                seen.result_ch0 !== want.result_ch0 ||
                seen.result_ch1 !== want.result_ch1 ||
                seen.result_ch2 !== want.result_ch2 ||
                seen.last_of_step !== want.last_of_step) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("%0t: expected row %0d col %0d border %0b ch %h %h %h last %0b",
                           $realtime, want.out_row, want.out_col, want.is_border,
                           want.result_ch0, want.result_ch1, want.result_ch2,
                           want.last_of_step);
                  $display("%0t: actual   row %0d col %0d border %0b ch %h %h %h last %0b",
                           $realtime, seen.out_row, seen.out_col, seen.is_border,
                           seen.result_ch0, seen.result_ch1, seen.result_ch2,
                           seen.last_of_step);
               end
            end
         end
      end
   end

   // Main sequence
   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_start_of_frame = 1'b0;
      req_pixel_ch0      = '0;
      req_pixel_ch1      = '0;
      req_pixel_ch2      = '0;
      rsp_stall          = 1'b0;
      csr_wr_en          = 1'b0;
      csr_index          = CSR_IMAGE_WIDTH;
      csr_wr_data        = '0;
      cfg_width          = WIDTH_RESET;
      cfg_height         = HEIGHT_RESET;
      cfg_color          = COLOR_RESET;
      row_pos            = 0;
      col_pos            = 0;
      foreach (older_line[i]) older_line[i] = '0;
      foreach (newer_line[i]) newer_line[i] = '0;
      foreach (window_px[i]) window_px[i] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_smallest_frame();
      test_size_limits();
      test_shrunken_format();
      test_backpressure();
      test_random_frames();

      wait_until_idle();
      $display("Sent %0d pixels in %0d formats with %0d frame starts; checked %0d results.",
               pixels_sent, formats_used, frame_starts, results_checked);
      $display("Formats ranged over zero, saturated and shrunk sizes in gray and colour.");
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d result errors", error_count);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // End a hung run
   initial begin
      #3_000_000;
      $display("Timed out with %0d results outstanding", expected_pixels.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== files.f =====
sv/bfm_pkg.sv
sv/bfm_line_store.sv
sv/bfm_window_sum.sv
sv/bfm_out_queue.sv
sv/box_filter_3x3_mean.sv
sv/bfm_checker.sv
tb/tb_box_filter_3x3_mean.sv
